[sv/ffba_pkg.sv]
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

	localparam int ENTRIES  = 64;
	localparam int TAG_BITS = 16;
	localparam int AW       = $clog2(ENTRIES);
	localparam int IDX_W    = $clog2(ENTRIES + 1);
	localparam logic [IDX_W-1:0] NIL = IDX_W'(ENTRIES);

	localparam logic [1:0] FN_ALLOC    = 2'd0;
	localparam logic [1:0] FN_FREE_ID  = 2'd1;
	localparam logic [1:0] FN_FREE_TAG = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOMEM = 2'd1;
	localparam logic [1:0] ST_BADID = 2'd2;

	localparam logic [1:0] REG_BASE    = 2'd0;
	localparam logic [1:0] REG_LENGTH  = 2'd1;
	localparam logic [1:0] REG_GRANULE = 2'd2;

	typedef struct packed {
		logic [1:0]          func;
		logic [31:0]         req_size;
		logic [31:0]         req_id;
		logic [TAG_BITS-1:0] owner;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  grant_id;
		logic [31:0] grant_offset;
	} rsp_t;

	typedef struct packed {
		logic [IDX_W-1:0]    nxt;
		logic [IDX_W-1:0]    prv;
		logic [31:0]         start;
		logic [31:0]         len;
		logic [TAG_BITS-1:0] owner;
		logic                busy;
	} desc_t;

endpackage

[sv/first_fit_block_allocator.sv]
// First-fit block allocator: descriptor memory and list-walking sequencer.
// One request at a time. The descriptors sit in a single-port memory with a registered
// read, so every list entry visited takes an address state and then a data state.
// Allocate walks the list for the first free block that fits and splits off the rest
// when it is larger; free by id includes both merges; free by tag walks the list and
// releases every block of that tag, merging each. The S_DONE state passes the result word
// to the output register once that is free or being taken; the register then holds it
// until taken while the next request proceeds.
// After reset and after any write of the base or length register the pool is ready at once.
module first_fit_block_allocator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  ffba_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output ffba_pkg::rsp_t   rsp,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import ffba_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_A_RD, S_A_CHK, S_A_SP_RD, S_A_SP, S_A_CUR, S_A_NB_RD, S_A_NB,
		S_R_RD, S_R_CHK, S_R_P_RD, S_R_P, S_AB_RD, S_AB_N, S_AB_SPR, S_AB_NN_RD,
		S_AB_NN, S_AB_END, S_W_RD, S_W_CHK, S_DONE
	} state_t;

	state_t              state_q;
	logic [31:0]         base_q, length_q;
	logic [4:0]          granule_q;
	logic [1:0]          func_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [31:0]         size_q;
	logic [IDX_W-1:0]    cur_q, steps_q, spare_q, x_q, n_q, nn_q, e_q;
	desc_t               xe_q, ne_q;
	logic                phase_q;
	rsp_t                res_q, out_q;
	logic                out_valid_q;
	logic [ENTRIES-1:0]  vld_q;

	desc_t               mem_q [ENTRIES];
	desc_t               rd_q;
	logic                rd_vld_q;
	logic [AW-1:0]       rd_idx_q;

	logic                rd_en, we;
	logic [AW-1:0]       raddr, waddr;
	desc_t               wdata, ent;
	logic                cfg_wr, fit;
	logic [31:0]         gmask;

	function automatic desc_t reset_desc(logic [AW-1:0] idx, logic [31:0] b, logic [31:0] l);
		desc_t d;
		d = '0;
		d.nxt = (idx >= AW'(1) && idx <= AW'(ENTRIES - 2)) ? IDX_W'(idx) + IDX_W'(1) : NIL;
		d.prv = NIL;
		d.start = (idx == '0) ? b : 32'd0;
		d.len = (idx == '0) ? l : 32'd0;
		return d;
	endfunction

	// an entry never written since the last re-initialisation reads as its reset value
	assign ent = rd_vld_q ? rd_q : reset_desc(rd_idx_q, base_q, length_q);
	assign fit = !ent.busy && ent.len >= size_q;
	assign gmask = (32'd1 << granule_q) - 32'd1;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	always_comb begin
		case (paddr[3:2])
			REG_BASE:    prdata = base_q;
			REG_LENGTH:  prdata = length_q;
			REG_GRANULE: prdata = {27'd0, granule_q};
			default:     prdata = 32'd0;
		endcase
	end

	// memory port selection
	always_comb begin
		rd_en = 1'b0;
		raddr = cur_q[AW-1:0];
		we = 1'b0;
		waddr = x_q[AW-1:0];
		wdata = xe_q;
		case (state_q)
			S_A_RD, S_W_RD: begin
				rd_en = 1'b1;
				raddr = cur_q[AW-1:0];
			end
			S_A_CHK: begin
				we = fit && size_q == ent.len;
				waddr = cur_q[AW-1:0];
				wdata = ent;
				wdata.busy = 1'b1;
				wdata.owner = tag_q;
			end
			S_A_SP_RD: begin
				rd_en = 1'b1;
				raddr = spare_q[AW-1:0];
			end
			S_A_SP: begin
				we = 1'b1;
				waddr = spare_q[AW-1:0];
				wdata = ent;
				wdata.nxt = xe_q.nxt;
				wdata.prv = x_q;
				wdata.busy = 1'b0;
				wdata.start = xe_q.start + size_q;
				wdata.len = xe_q.len - size_q;
			end
			S_A_CUR: begin
				we = 1'b1;
				wdata = xe_q;
				wdata.nxt = e_q;
				wdata.len = size_q;
				wdata.busy = 1'b1;
				wdata.owner = tag_q;
			end
			S_A_NB_RD, S_AB_RD: begin
				rd_en = 1'b1;
				raddr = xe_q.nxt[AW-1:0];
			end
			S_A_NB: begin
				we = 1'b1;
				waddr = xe_q.nxt[AW-1:0];
				wdata = ent;
				wdata.prv = e_q;
			end
			S_R_RD: begin
				rd_en = 1'b1;
				raddr = x_q[AW-1:0];
			end
			S_R_CHK: begin
				we = ent.busy && ent.owner == tag_q;
				wdata = ent;
				wdata.busy = 1'b0;
			end
			S_R_P_RD: begin
				rd_en = 1'b1;
				raddr = xe_q.prv[AW-1:0];
			end
			S_AB_N: begin
				we = !(phase_q && ent.busy);
				wdata = xe_q;
				wdata.len = xe_q.len + ent.len;
				wdata.nxt = ent.nxt;
			end
			S_AB_SPR: begin
				we = 1'b1;
				waddr = n_q[AW-1:0];
				wdata = ne_q;
				wdata.nxt = spare_q;
			end
			S_AB_NN_RD: begin
				rd_en = 1'b1;
				raddr = nn_q[AW-1:0];
			end
			S_AB_NN: begin
				we = 1'b1;
				waddr = nn_q[AW-1:0];
				wdata = ent;
				wdata.prv = x_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (rd_en) begin
			rd_q <= mem_q[raddr];
			rd_idx_q <= raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			base_q <= 32'd0;
			length_q <= 32'd0;
			granule_q <= 5'd12;
			spare_q <= IDX_W'(1);
			vld_q <= '0;
			rd_vld_q <= 1'b0;
			out_valid_q <= 1'b0;
			func_q <= FN_ALLOC;
			tag_q <= '0;
			size_q <= '0;
			cur_q <= '0;
			steps_q <= '0;
			x_q <= '0;
			n_q <= '0;
			nn_q <= '0;
			e_q <= '0;
			xe_q <= '0;
			ne_q <= '0;
			phase_q <= 1'b0;
			res_q <= '0;
			out_q <= '0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || rsp_ready))
				out_valid_q <= 1'b1;
			else if (rsp_valid && rsp_ready)
				out_valid_q <= 1'b0;
			if (cfg_wr && (paddr[3:2] == REG_BASE || paddr[3:2] == REG_LENGTH))
				vld_q <= '0;
			else if (we)
				vld_q[waddr] <= 1'b1;
			if (rd_en)
				rd_vld_q <= vld_q[raddr];
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_BASE: begin
						base_q <= pwdata;
						spare_q <= IDX_W'(1);
					end
					REG_LENGTH: begin
						length_q <= pwdata;
						spare_q <= IDX_W'(1);
					end
					REG_GRANULE: granule_q <= pwdata[4:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						func_q <= req.func;
						tag_q <= req.owner;
						size_q <= (req.req_size + gmask) & ~gmask;
						cur_q <= '0;
						steps_q <= '0;
						res_q <= '{status: ST_BADID, grant_id: 7'd0, grant_offset: 32'd0};
						case (req.func)
							FN_ALLOC: state_q <= S_A_RD;
							FN_FREE_ID: begin
								if (req.req_id != 32'd0 && req.req_id <= 32'(ENTRIES)) begin
									x_q <= IDX_W'(req.req_id - 32'd1);
									state_q <= S_R_RD;
								end else
									state_q <= S_DONE;
							end
							FN_FREE_TAG: state_q <= S_W_RD;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_A_RD: state_q <= S_A_CHK;
				S_A_CHK: begin
					if (fit) begin
						x_q <= cur_q;
						xe_q <= ent;
						if (size_q == ent.len) begin
							res_q <= '{status: ST_OK, grant_id: 7'(cur_q + IDX_W'(1)),
								grant_offset: ent.start};
							state_q <= S_DONE;
						end else if (spare_q >= NIL) begin
							res_q.status <= ST_NOMEM;
							state_q <= S_DONE;
						end else
							state_q <= S_A_SP_RD;
					end else if (ent.nxt >= NIL || steps_q == IDX_W'(ENTRIES)) begin
						res_q.status <= ST_NOMEM;
						state_q <= S_DONE;
					end else begin
						cur_q <= ent.nxt;
						steps_q <= steps_q + IDX_W'(1);
						state_q <= S_A_RD;
					end
				end
				S_A_SP_RD: state_q <= S_A_SP;
				S_A_SP: begin
					e_q <= spare_q;
					spare_q <= ent.nxt;
					state_q <= S_A_CUR;
				end
				S_A_CUR: begin
					res_q <= '{status: ST_OK, grant_id: 7'(x_q + IDX_W'(1)),
						grant_offset: xe_q.start};
					state_q <= (xe_q.nxt < NIL) ? S_A_NB_RD : S_DONE;
				end
				S_A_NB_RD: state_q <= S_A_NB;
				S_A_NB: state_q <= S_DONE;
				S_R_RD: state_q <= S_R_CHK;
				S_R_CHK: begin
					if (!(ent.busy && ent.owner == tag_q))
						state_q <= S_DONE;
					else begin
						xe_q <= wdata;
						phase_q <= 1'b1;
						state_q <= (ent.prv < NIL) ? S_R_P_RD : S_AB_RD;
					end
				end
				S_R_P_RD: state_q <= S_R_P;
				S_R_P: begin
					// free predecessor takes this block over
					if (!ent.busy) begin
						x_q <= xe_q.prv;
						xe_q <= ent;
						phase_q <= 1'b0;
					end
					state_q <= S_AB_RD;
				end
				S_AB_RD: state_q <= (xe_q.nxt >= NIL) ? S_AB_END : S_AB_N;
				S_AB_N: begin
					if (phase_q && ent.busy)
						state_q <= S_AB_END;
					else begin
						n_q <= xe_q.nxt;
						nn_q <= ent.nxt;
						ne_q <= ent;
						xe_q <= wdata;
						state_q <= S_AB_SPR;
					end
				end
				S_AB_SPR: begin
					spare_q <= n_q;
					state_q <= (nn_q < NIL) ? S_AB_NN_RD : S_AB_END;
				end
				S_AB_NN_RD: state_q <= S_AB_NN;
				S_AB_NN: state_q <= S_AB_END;
				S_AB_END: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
						state_q <= S_AB_RD;
					end else if (func_q == FN_FREE_ID) begin
						res_q.status <= ST_OK;
						state_q <= S_DONE;
					end else begin
						cur_q <= xe_q.nxt;
						steps_q <= steps_q + IDX_W'(1);
						if (xe_q.nxt < NIL && steps_q < IDX_W'(ENTRIES - 1))
							state_q <= S_W_RD;
						else begin
							res_q.status <= ST_OK;
							state_q <= S_DONE;
						end
					end
				end
				S_W_RD: state_q <= S_W_CHK;
				S_W_CHK: begin
					if (ent.busy && ent.owner == tag_q) begin
						x_q <= cur_q;
						state_q <= S_R_CHK;
					end else begin
						cur_q <= ent.nxt;
						steps_q <= steps_q + IDX_W'(1);
						if (ent.nxt < NIL && steps_q < IDX_W'(ENTRIES - 1))
							state_q <= S_W_RD;
						else begin
							res_q.status <= ST_OK;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp_ready) begin
						out_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_spare_range: assert property (@(posedge clk) disable iff (!arst_n)
		spare_q <= NIL) else $error("spare head beyond null");

	a_walk_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_A_RD || state_q == S_W_RD) |-> cur_q < NIL)
		else $error("walk reads a null descriptor");

	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.grant_id == 7'd0)
		else $error("grant id on a failed request");

	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second word taken while busy");

endmodule
